// ===== hdl/memory_block_fit_allocator_top_defines.svh =====
// Assertion macros used by the checker of the block fit allocator.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef MEMORY_BLOCK_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define MEMORY_BLOCK_FIT_ALLOCATOR_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is applied.
`define MBFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MBFA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mbfa_pkg.sv =====
// Shared types, codes and default sizes of the block fit allocator.
// Depends on nothing; used by the top level, the checker and the testbench.
package mbfa_pkg;

	localparam int MBFA_MAX_BLOCKS = 64;
	localparam int MBFA_SIZE_BITS  = 16;
	localparam int MBFA_IDX_BITS   = 6;
	localparam int MBFA_REQ_BITS   = 16;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_NEWRUN = 2'd2,
		FUNC_ALLOC  = 2'd3
	} mbfa_func_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} mbfa_status_t;

	typedef enum logic [1:0] {
		MODE_BEST  = 2'd0,
		MODE_FIRST = 2'd1,
		MODE_WORST = 2'd2
	} mbfa_mode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_SWEEP
	} mbfa_state_t;

endpackage

// ===== hdl/mbfa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module mbfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/memory_block_fit_allocator_top.sv =====
// Block fit allocator: clear, append, and a new run or an allocation on an empty table
// put their result beat in the cycle after the command beat, and busy stays low for them.
// A new run otherwise walks the stored blocks in the mark-clearing sweep; an allocation
// reads the size and mark memories once per stored block, then decides and marks in a
// final step. The next command is taken at the edge ending the result beat, and results
// are never held off. Reset clears the count, the mode and all control.
module memory_block_fit_allocator_top
	import mbfa_pkg::*;
#(
	parameter int MAX_BLOCKS = MBFA_MAX_BLOCKS,
	parameter int SIZE_BITS  = MBFA_SIZE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               func,
	input  logic [MBFA_REQ_BITS-1:0] size,
	output logic                     busy,
	output logic                     done,
	output logic [1:0]               status,
	output logic [MBFA_IDX_BITS-1:0] block_index,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_data
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	mbfa_state_t state_q, state_d;

	logic [CW-1:0]            count_q;
	logic [AW-1:0]            ptr_q;
	logic [1:0]               mode_q;
	logic [SIZE_BITS-1:0]     req_q;
	logic                     rd_valid_s1;
	logic [AW-1:0]            idx_s1;
	logic                     found_q;
	logic [AW-1:0]            best_q;
	logic [SIZE_BITS-1:0]     best_size_q;
	logic                     done_q;
	logic [1:0]               status_q;
	logic [MBFA_IDX_BITS-1:0] index_q;

	logic [SIZE_BITS-1:0]     size_in;
	logic [SIZE_BITS-1:0]     size_rdata;
	logic                     used_rdata;
	logic                     size_we;
	logic                     used_we;
	logic                     used_wdata;
	logic [AW-1:0]            wr_addr;
	logic                     ptr_last;
	logic                     fits;
	logic                     better;
	logic                     take;
	logic                     found_n;
	logic [AW-1:0]            pick_n;
	logic                     res_set;
	logic [1:0]               res_status;
	logic [MBFA_IDX_BITS-1:0] res_index;
	logic                     accept;

	assign size_in   = SIZE_BITS'(size);
	assign accept    = start && (state_q == S_IDLE);
	assign ptr_last  = (CW'(ptr_q) == (count_q - CW'(1)));
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign done        = done_q;
	assign status      = status_q;
	assign block_index = index_q;

	mbfa_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_BLOCKS)
	) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (wr_addr),
		.wdata (size_in),
		.raddr (ptr_q),
		.rdata (size_rdata)
	);

	mbfa_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BLOCKS)
	) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (wr_addr),
		.wdata (used_wdata),
		.raddr (ptr_q),
		.rdata (used_rdata)
	);

	assign fits   = rd_valid_s1 && !used_rdata && (size_rdata >= req_q);
	assign better = (mode_q == MODE_WORST) ? (size_rdata > best_size_q)
	                                       : (size_rdata < best_size_q);
	assign take    = fits && (!found_q || ((mode_q != MODE_FIRST) && better));
	assign found_n = found_q || fits;
	assign pick_n  = take ? idx_s1 : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		size_we    = 1'b0;
		used_we    = 1'b0;
		used_wdata = 1'b0;
		wr_addr    = ptr_q;
		res_set    = 1'b0;
		res_status = STAT_OK;
		res_index  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (func)
						FUNC_CLEAR: begin
							res_set = 1'b1;
						end
						FUNC_APPEND: begin
							res_set = 1'b1;
							if (count_q == CW'(MAX_BLOCKS)) begin
								res_status = STAT_FULL;
							end else begin
								size_we   = 1'b1;
								used_we   = 1'b1;
								wr_addr   = count_q[AW-1:0];
								res_index = MBFA_IDX_BITS'(count_q);
							end
						end
						FUNC_NEWRUN: begin
							if (count_q == '0) begin
								res_set = 1'b1;
							end else begin
								state_d = S_SWEEP;
							end
						end
						FUNC_ALLOC: begin
							if (count_q == '0) begin
								res_set    = 1'b1;
								res_status = STAT_MISS;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: begin
							res_set = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (ptr_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
				res_set = 1'b1;
				if (found_n) begin
					used_we    = 1'b1;
					used_wdata = 1'b1;
					wr_addr    = pick_n;
					res_index  = MBFA_IDX_BITS'(pick_n);
				end else begin
					res_status = STAT_MISS;
				end
			end
			S_SWEEP: begin
				used_we = 1'b1;
				if (ptr_last) begin
					state_d = S_IDLE;
					res_set = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			mode_q      <= MODE_BEST;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q      <= res_set;
			rd_valid_s1 <= (state_q == S_SCAN);
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (state_q == S_IDLE) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
			end else begin
				ptr_q <= ptr_q + AW'(1);
				if (rd_valid_s1) begin
					found_q <= found_n;
				end
			end
			if (accept && (func == FUNC_CLEAR)) begin
				count_q <= '0;
			end else if (size_we) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		if (accept) begin
			req_q <= size_in;
		end
		if (take) begin
			best_q      <= idx_s1;
			best_size_q <= size_rdata;
		end
		status_q <= res_status;
		index_q  <= res_index;
	end

endmodule

// ===== hdl/mbfa_checker.sv =====
// Port-level checks of the block fit allocator, bound to its top level.
// Depends on mbfa_pkg and memory_block_fit_allocator_top_defines.svh.
`include "memory_block_fit_allocator_top_defines.svh"

module mbfa_checker
	import mbfa_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic [1:0]               status,
	input logic [MBFA_IDX_BITS-1:0] block_index
);

	`MBFA_ASSERT(a_accept_moves, (start && !busy) |=> (busy || done), "Accepted beat went nowhere.")
	`MBFA_ASSERT(a_done_has_cause, done |-> $past(busy || start), "Result beat without a command.")
	`MBFA_ASSERT(a_finish_reports, $fell(busy) |-> done, "Command finished without a result beat.")
	`MBFA_ASSERT(a_index_zero, done |-> ((status == STAT_OK) || (block_index == '0)), "Index set on a failed result beat.")

endmodule

bind memory_block_fit_allocator_top mbfa_checker u_mbfa_checker (.*);

// ===== sim/memory_block_fit_allocator_top_test.sv =====
// Self-checking testbench for memory_block_fit_allocator_top: a queue-fed command driver,
// a monitor with a built-in predictor of the block table and fit policy, random idling.
// Depends on mbfa_pkg and the memory_block_fit_allocator_top RTL.
module memory_block_fit_allocator_top_test
	import mbfa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int               CYCLE_LIMIT     = 600000;
	localparam int               PHASE_ITEMS     = 205;
	localparam logic [1:0]       MODE_UNDEF_BEST = 2'd3;
	localparam logic [15:0]      SIZE_MAX        = 16'hFFFF;

	typedef struct packed {
		mbfa_func_t                 op;
		logic [MBFA_REQ_BITS-1:0]   amount;
	} alloc_cmd_t;

	typedef struct packed {
		mbfa_status_t               status;
		logic [MBFA_IDX_BITS-1:0]   index;
	} grant_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic [1:0]                 func = FUNC_CLEAR;
	logic [MBFA_REQ_BITS-1:0]   size = '0;
	logic                       busy;
	logic                       done;
	logic [1:0]                 status;
	logic [MBFA_IDX_BITS-1:0]   block_index;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [1:0]                 cfg_data = MODE_BEST;

	alloc_cmd_t cmd_backlog[$];
	grant_t     expected_grants[$];

	logic [MBFA_SIZE_BITS-1:0]  shadow_sizes [MBFA_MAX_BLOCKS];
	logic                       shadow_used [MBFA_MAX_BLOCKS];
	int                         shadow_count = 0;
	logic [1:0]                 shadow_mode = MODE_BEST;

	logic [15:0]                gen_sizes [MBFA_MAX_BLOCKS];
	int                         gen_count = 0;
	int                         phase_items = 0;

	logic                       item_taken = 1'b0;
	logic                       steady = 1'b0;
	int                         gap_left = 0;
	int                         mismatch_count = 0;
	int                         cycle_count = 0;

	memory_block_fit_allocator_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.size        (size),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.block_index (block_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		for (int i = 0; i < MBFA_MAX_BLOCKS; i++) begin
			shadow_used[i] = 1'b0;
			shadow_sizes[i] = '0;
			gen_sizes[i] = '0;
		end
	end

	function automatic grant_t fit_step(mbfa_func_t op, logic [15:0] amount);
		grant_t res;
		bit found;
		int pick;
		res.status = STAT_OK;
		res.index = '0;
		found = 1'b0;
		pick = 0;
		case (op)
			FUNC_CLEAR: begin
				shadow_count = 0;
				for (int i = 0; i < MBFA_MAX_BLOCKS; i++) shadow_used[i] = 1'b0;
			end
			FUNC_APPEND: begin
				if (shadow_count >= MBFA_MAX_BLOCKS) begin
					res.status = STAT_FULL;
				end else begin
					shadow_sizes[shadow_count] = amount;
					shadow_used[shadow_count] = 1'b0;
					res.index = shadow_count[MBFA_IDX_BITS-1:0];
					shadow_count++;
				end
			end
			FUNC_NEWRUN: begin
				for (int i = 0; i < MBFA_MAX_BLOCKS; i++) shadow_used[i] = 1'b0;
			end
			default: begin
				for (int j = 0; j < shadow_count; j++) begin
					if (!shadow_used[j] && shadow_sizes[j] >= amount) begin
						if (!found) begin
							found = 1'b1;
							pick = j;
							if (shadow_mode == MODE_FIRST) break;
						end else if (shadow_mode == MODE_WORST) begin
							if (shadow_sizes[j] > shadow_sizes[pick]) pick = j;
						end else if (shadow_sizes[j] < shadow_sizes[pick]) begin
							pick = j;
						end
					end
				end
				if (found) begin
					shadow_used[pick] = 1'b1;
					res.index = pick[MBFA_IDX_BITS-1:0];
				end else begin
					res.status = STAT_MISS;
				end
			end
		endcase
		return res;
	endfunction

	// Monitor: checks each result beat, then records the command beat taken at this edge.
	always @(posedge clk) begin : watch_beats
		grant_t want;
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("memory_block_fit_allocator_top_test: errors");
			$finish;
		end
		item_taken = arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (expected_grants.size() == 0) begin
					$display("%0t: unexpected result status=%0d block_index=%0d",
						$time, status, block_index);
					mismatch_count++;
				end else begin
					want = expected_grants.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						mismatch_count++;
					end
					if (block_index !== want.index) begin
						$display("%0t: block_index expected %0d actual %0d",
							$time, want.index, block_index);
						mismatch_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) shadow_mode = cfg_data;
			if (item_taken) expected_grants.push_back(fit_step(mbfa_func_t'(func), size));
		end
	end

	// Driver: presents queued commands, with a random gap after each accepted beat.
	always @(negedge clk) begin : drive_cmds
		logic next_start;
		alloc_cmd_t cmd;
		next_start = start;
		if (arst_n) begin
			if (start && item_taken) begin
				void'(cmd_backlog.pop_front());
				if ($urandom_range(0, 31) == 0) steady = !steady;
				gap_left = steady ? 0 : $urandom_range(0, 11);
				next_start = 1'b0;
			end else if (!start && gap_left > 0) begin
				gap_left--;
			end
			if (!next_start && gap_left == 0 && cmd_backlog.size() != 0) begin
				cmd = cmd_backlog[0];
				next_start = 1'b1;
				func <= cmd.op;
				size <= cmd.amount;
			end
		end
		start <= next_start;
	end

	task automatic queue_cmd(mbfa_func_t op, logic [15:0] amount);
		alloc_cmd_t cmd;
		cmd.op = op;
		cmd.amount = amount;
		cmd_backlog.push_back(cmd);
		phase_items++;
		if (op == FUNC_CLEAR) begin
			gen_count = 0;
		end else if (op == FUNC_APPEND && gen_count < MBFA_MAX_BLOCKS) begin
			gen_sizes[gen_count] = amount;
			gen_count++;
		end
	endtask

	task automatic write_fit_mode(logic [1:0] mode);
		@(negedge clk);
		cfg_data <= mode;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || expected_grants.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_block_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 16'($urandom_range(1, 8) * 256);
		if (r < 70) return 16'($urandom_range(0, 65535));
		if (r < 80) return '0;
		if (r < 90) return SIZE_MAX;
		return 16'($urandom_range(0, 15));
	endfunction

	function automatic logic [15:0] pick_request();
		int r;
		logic [15:0] base;
		r = $urandom_range(0, 99);
		if (gen_count == 0 || r < 15) return 16'($urandom_range(0, 65535));
		if (r < 20) return '0;
		if (r < 25) return SIZE_MAX;
		base = gen_sizes[$urandom_range(0, gen_count - 1)];
		if (r < 70) return base;
		if (r < 85) return base + 16'd1;
		return base - 16'd1;
	endfunction

	task automatic queue_sequence();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			n = $urandom_range(1, 8);
			repeat (n) queue_cmd(FUNC_ALLOC, pick_request());
		end else if (r < 65) begin
			n = $urandom_range(1, 6);
			repeat (n) queue_cmd(FUNC_APPEND, pick_block_size());
		end else if (r < 75) begin
			queue_cmd(FUNC_NEWRUN, 16'($urandom_range(0, 65535)));
		end else if (r < 85) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			queue_cmd(FUNC_CLEAR, 16'($urandom_range(0, 65535)));
			repeat (n) queue_cmd(FUNC_APPEND, pick_block_size());
			n = $urandom_range(2, 10);
			repeat (n) queue_cmd(FUNC_ALLOC, pick_request());
		end else if (r < 90) begin
			while (gen_count < MBFA_MAX_BLOCKS) queue_cmd(FUNC_APPEND, pick_block_size());
			n = $urandom_range(1, 3);
			repeat (n) queue_cmd(FUNC_APPEND, pick_block_size());
			n = $urandom_range(2, 8);
			repeat (n) queue_cmd(FUNC_ALLOC, pick_request());
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) queue_cmd(mbfa_func_t'($urandom_range(0, 3)),
				16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin : stimulus
		logic [1:0] mode_plan [6];
		mode_plan = '{MODE_FIRST, MODE_WORST, MODE_UNDEF_BEST, MODE_BEST, MODE_WORST,
			MODE_FIRST};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs with the policy left at its reset value, best fit.
		queue_cmd(FUNC_ALLOC, '0);
		queue_cmd(FUNC_APPEND, '0);
		queue_cmd(FUNC_APPEND, SIZE_MAX);
		queue_cmd(FUNC_APPEND, 16'd1);
		queue_cmd(FUNC_APPEND, 16'h5555);
		queue_cmd(FUNC_APPEND, 16'hAAAA);
		queue_cmd(FUNC_APPEND, SIZE_MAX);
		queue_cmd(FUNC_ALLOC, '0);
		queue_cmd(FUNC_ALLOC, '0);
		queue_cmd(FUNC_ALLOC, SIZE_MAX);
		queue_cmd(FUNC_ALLOC, SIZE_MAX);
		queue_cmd(FUNC_ALLOC, SIZE_MAX);
		queue_cmd(FUNC_ALLOC, 16'd2);
		queue_cmd(FUNC_NEWRUN, '0);
		queue_cmd(FUNC_ALLOC, SIZE_MAX);
		queue_cmd(FUNC_CLEAR, SIZE_MAX);
		queue_cmd(FUNC_ALLOC, '0);
		queue_cmd(FUNC_APPEND, 16'h8000);
		queue_cmd(FUNC_ALLOC, 16'h7FFF);
		queue_cmd(FUNC_NEWRUN, SIZE_MAX);
		queue_cmd(FUNC_ALLOC, 16'h8000);
		wait_drained();

		foreach (mode_plan[p]) begin
			write_fit_mode(mode_plan[p]);
			@(posedge clk);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) queue_sequence();
			wait_drained();
		end

		repeat (80) @(posedge clk);
		if (expected_grants.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_grants.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("memory_block_fit_allocator_top_test: clean");
		end else begin
			$display("memory_block_fit_allocator_top_test: errors");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mbfa_pkg.sv
hdl/mbfa_ram.sv
hdl/memory_block_fit_allocator_top.sv
hdl/mbfa_checker.sv
sim/memory_block_fit_allocator_top_test.sv
